>>> design/stack_expression_alu_core_assert.svh
// Assertion macros for the stack ALU controller.
`ifndef STACK_EXPRESSION_ALU_CORE_ASSERT_SVH
`define STACK_EXPRESSION_ALU_CORE_ASSERT_SVH

// Implication checked at every rising clock edge, reset masks it.
`define SEA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("implication assertion failed");

// Next-cycle implication.
`define SEA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

>>> design/sea_pkg.sv
package sea_pkg;
	localparam int STACK_DEPTH_DEF = 64;
	localparam int DATA_W = 32;
	localparam int DEPTH_W = 7;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_PUSH  = 2'd1,
		CMD_POP   = 2'd2,
		CMD_BINOP = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_OVERFLOW  = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_BADOP     = 3'd3,
		ST_DIVZERO   = 3'd4
	} status_t;

	localparam logic [4:0] OP_ADD = 5'd0;
	localparam logic [4:0] OP_SUB = 5'd1;
	localparam logic [4:0] OP_MUL = 5'd2;
	localparam logic [4:0] OP_DIV = 5'd3;
	localparam logic [4:0] OP_MOD = 5'd4;
	localparam logic [4:0] OP_LT = 5'd5;
	localparam logic [4:0] OP_GT = 5'd6;
	localparam logic [4:0] OP_LE = 5'd7;
	localparam logic [4:0] OP_GE = 5'd8;
	localparam logic [4:0] OP_NE = 5'd9;
	localparam logic [4:0] OP_LAND = 5'd10;
	localparam logic [4:0] OP_LOR = 5'd11;
	localparam logic [4:0] OP_EQ = 5'd12;
	localparam logic [4:0] OP_OR = 5'd13;
	localparam logic [4:0] OP_AND = 5'd14;
	localparam logic [4:0] OP_XOR = 5'd15;
	localparam logic [4:0] OP_SHL = 5'd16;
	localparam logic [4:0] OP_SHR = 5'd17;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_X,
		S_RD_Y,
		S_WAIT_Y,
		S_LATCH_Y,
		S_EXEC,
		S_DIV,
		S_WRITE,
		S_POP_WAIT,
		S_POP_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic ram_we;        // write res_q (or operand) at waddr
		logic ram_we_val;    // write data is operand, else result
		logic ram_re;
		logic rd_top;        // read address depth-1, else depth-2
		logic cap_x;         // capture read data into x
		logic cap_y;
		logic cap_in;        // capture input beat
		logic alu_go;        // register the ALU result into res_q
		logic div_start;
		logic out_pop;       // emit read data as result
		logic depth_clr;
		logic depth_inc;
		logic depth_dec;
		logic depth_dec2;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic div_done;
		logic empty;
		logic lt2;
		logic full;
		logic x_zero;
	} sts_t;
endpackage

>>> design/sea_ram.sv
module sea_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule

>>> design/sea_div.sv
// Radix-2 restoring divider on magnitudes, signs fixed at the end.
module sea_div import sea_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] quo,
	output logic [DATA_W-1:0] rem
);
	logic [DATA_W-1:0] q_q, d_q;
	logic [DATA_W:0]   r_q;
	logic [5:0]        cnt_q;
	logic              busy_q, qneg_q, rneg_q;
	logic [DATA_W:0]   r_sh, r_sub;

	assign r_sh  = {r_q[DATA_W-1:0], q_q[DATA_W-1]};
	assign r_sub = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q    <= dividend[DATA_W-1] ? -dividend : dividend;
			d_q    <= divisor[DATA_W-1] ? -divisor : divisor;
			r_q    <= '0;
			qneg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			rneg_q <= dividend[DATA_W-1];
		end else if (busy_q) begin
			if (!r_sub[DATA_W]) begin
				r_q <= r_sub;
				q_q <= {q_q[DATA_W-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign quo = qneg_q ? -q_q : q_q;
	assign rem = rneg_q ? -r_q[DATA_W-1:0] : r_q[DATA_W-1:0];
endmodule

>>> design/sea_datapath.sv
module sea_datapath import sea_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	input  logic [DATA_W-1:0] in_value,
	input  logic [4:0]        in_opcode,
	output sts_t              sts,
	output logic [DATA_W-1:0] res_val,
	output logic [DEPTH_W-1:0] depth
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [CW-1:0]     cnt_q;
	logic [DATA_W-1:0] val_q, x_q, y_q, res_q, rdata;
	logic [4:0]        op_q;
	logic [DATA_W-1:0] alu_r, quo, rem, mul_r;
	logic [AW-1:0]     raddr, waddr;
	logic [CW-1:0]     ra_full;
	logic [DATA_W-1:0] lsh, rsh;
	logic              sh_ok;
	logic              div_done;

	assign ra_full = ctl.rd_top ? cnt_q - CW'(1) : cnt_q - CW'(2);
	assign raddr   = ra_full[AW-1:0];
	assign waddr   = cnt_q[AW-1:0];

	sea_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_ram (
		.clk(clk), .we(ctl.ram_we), .waddr(waddr),
		.wdata(ctl.ram_we_val ? val_q : res_q),
		.re(ctl.ram_re), .raddr(raddr), .rdata(rdata)
	);

	sea_div u_div (
		.clk(clk), .arst_n(arst_n), .start(ctl.div_start),
		.dividend(y_q), .divisor(x_q), .done(div_done), .quo(quo), .rem(rem)
	);

	assign mul_r = y_q * x_q;
	assign sh_ok = (x_q[DATA_W-1:5] == '0);
	assign lsh   = sh_ok ? (y_q << x_q[4:0]) : '0;
	assign rsh   = sh_ok ? DATA_W'($signed(y_q) >>> x_q[4:0]) : {DATA_W{y_q[DATA_W-1]}};

	always_comb begin
		alu_r = '0;
		unique case (op_q)
			OP_ADD:  alu_r = y_q + x_q;
			OP_SUB:  alu_r = y_q - x_q;
			OP_MUL:  alu_r = mul_r;
			OP_LT:   alu_r = DATA_W'($signed(y_q) < $signed(x_q));
			OP_GT:   alu_r = DATA_W'($signed(y_q) > $signed(x_q));
			OP_LE:   alu_r = DATA_W'($signed(y_q) <= $signed(x_q));
			OP_GE:   alu_r = DATA_W'($signed(y_q) >= $signed(x_q));
			OP_NE:   alu_r = DATA_W'(y_q != x_q);
			OP_LAND: alu_r = DATA_W'((y_q != '0) && (x_q != '0));
			OP_LOR:  alu_r = DATA_W'((y_q != '0) || (x_q != '0));
			OP_EQ:   alu_r = DATA_W'(y_q == x_q);
			OP_OR:   alu_r = y_q | x_q;
			OP_AND:  alu_r = y_q & x_q;
			OP_XOR:  alu_r = y_q ^ x_q;
			OP_SHL:  alu_r = lsh;
			OP_SHR:  alu_r = rsh;
			default: alu_r = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.cap_in) begin
			val_q <= in_value;
			op_q  <= in_opcode;
		end
		if (ctl.cap_x) x_q <= rdata;
		if (ctl.cap_y) y_q <= rdata;
		if (ctl.alu_go) res_q <= alu_r;
		else if (div_done) res_q <= (op_q == OP_DIV) ? quo : rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (ctl.depth_clr) cnt_q <= '0;
		else if (ctl.depth_inc) cnt_q <= cnt_q + CW'(1);
		else if (ctl.depth_dec) cnt_q <= cnt_q - CW'(1);
		else if (ctl.depth_dec2) cnt_q <= cnt_q - CW'(2);
	end

	assign sts.div_done = div_done;
	assign sts.empty    = (cnt_q == '0);
	assign sts.lt2      = (cnt_q < CW'(2));
	assign sts.full     = (cnt_q == CW'(STACK_DEPTH));
	assign sts.x_zero   = (rdata == '0);
	assign res_val      = ctl.out_pop ? rdata : (ctl.ram_we_val ? val_q : res_q);
	assign depth        = DEPTH_W'(cnt_q);
endmodule

>>> design/sea_ctrl.sv
module sea_ctrl import sea_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] command,
	input  logic [4:0] opcode,
	input  sts_t       sts,
	output ctl_t       ctl,
	output logic       busy,
	output logic       done,
	output logic [2:0] st
);
	`include "stack_expression_alu_core_assert.svh"

	state_t state_q, state_d;
	logic   div_q, div_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			div_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			div_q   <= div_d;
		end
	end

	always_comb begin
		state_d = state_q;
		div_d   = div_q;
		ctl     = '0;
		done    = 1'b0;
		st      = ST_OK;
		busy    = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				ctl.cap_in = start;
				if (start) begin
					unique case (cmd_t'(command))
						CMD_CLEAR: begin
							ctl.depth_clr = 1'b1;
							done = 1'b1;
						end
						CMD_PUSH: begin
							if (sts.full) begin
								st = ST_OVERFLOW;
								done = 1'b1;
							end else state_d = S_WRITE;
							div_d = 1'b0;
						end
						CMD_POP: begin
							if (sts.empty) begin
								st = ST_UNDERFLOW;
								done = 1'b1;
							end else begin
								ctl.ram_re = 1'b1;
								ctl.rd_top = 1'b1;
								state_d = S_POP_WAIT;
							end
						end
						CMD_BINOP: begin
							if (sts.lt2) begin
								st = ST_UNDERFLOW;
								done = 1'b1;
							end else if (opcode > OP_SHR) begin
								st = ST_BADOP;
								done = 1'b1;
							end else begin
								ctl.ram_re = 1'b1;
								ctl.rd_top = 1'b1;
								div_d = (opcode == OP_DIV) || (opcode == OP_MOD);
								state_d = S_RD_X;
							end
						end
						default: ;
					endcase
				end
			end
			S_POP_WAIT: begin
				ctl.out_pop = 1'b1;
				ctl.depth_dec = 1'b1;
				done = 1'b1;
				state_d = S_IDLE;
			end
			S_RD_X: begin
				ctl.cap_x = 1'b1;
				ctl.ram_re = 1'b1;
				state_d = S_RD_Y;
				if (div_q && sts.x_zero) begin
					ctl.ram_re = 1'b0;
					ctl.depth_dec2 = 1'b1;
					st = ST_DIVZERO;
					done = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RD_Y: begin
				ctl.cap_y = 1'b1;
				ctl.depth_dec2 = 1'b1;
				state_d = div_q ? S_WAIT_Y : S_EXEC;
			end
			S_WAIT_Y: begin
				// both operands now registered
				ctl.div_start = 1'b1;
				state_d = S_DIV;
			end
			S_EXEC: begin
				ctl.alu_go = 1'b1;
				state_d = S_LATCH_Y;
			end
			S_DIV: begin
				if (sts.div_done) state_d = S_LATCH_Y;
			end
			S_LATCH_Y: begin
				// result register holds the value; push it
				ctl.ram_we = 1'b1;
				ctl.depth_inc = 1'b1;
				done = 1'b1;
				state_d = S_IDLE;
			end
			S_WRITE: begin
				ctl.ram_we = 1'b1;
				ctl.ram_we_val = 1'b1;
				ctl.depth_inc = 1'b1;
				done = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	`SEA_ASSERT_IMP(a_done_busy, clk, arst_n, done && state_q == S_IDLE, start)
	`SEA_ASSERT_NXT(a_done_idle, clk, arst_n, done, state_q == S_IDLE)
	`SEA_ASSERT_IMP(a_we_one, clk, arst_n, ctl.ram_we, !ctl.ram_re)
endmodule

>>> design/stack_expression_alu_core.sv
// Stack ALU: an evaluation stack of 32-bit signed values with an integer ALU.
// Issue a command by raising start while busy is low; each command gives one
// result beat on result_valid, held one cycle only, and the receiver cannot
// stall it. Clear, overflow, underflow and bad opcode are answered from the
// idle state; push and pop pass one more state (write, or pop read), as does
// divide by zero (the x read); a binary operation reads x and y, executes and
// pushes the result back; div/mod reads both operands, runs the
// one-bit-per-cycle divider (32 iterations) and pushes the result back. A new
// command can be accepted in the result cycle. The stack sits in a
// single-port-read RAM, so the two operands are read in consecutive cycles.
module stack_expression_alu_core import sea_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               command,
	input  logic signed [DATA_W-1:0] operand_value,
	input  logic [4:0]               opcode,
	output logic                     result_valid,
	output logic signed [DATA_W-1:0] result_value,
	output logic [2:0]               status,
	output logic [DEPTH_W-1:0]       stack_depth
);
	ctl_t              ctl;
	sts_t              sts;
	logic [DATA_W-1:0] dp_val;
	logic [DEPTH_W-1:0] dp_depth;
	logic              done;
	logic [2:0]        st;

	sea_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .command(command),
		.opcode(opcode), .sts(sts), .ctl(ctl), .busy(busy), .done(done), .st(st)
	);

	sea_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .in_value(operand_value),
		.in_opcode(opcode), .sts(sts), .res_val(dp_val), .depth(dp_depth)
	);

	// Result beat registered: depth after the command is settled next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= done;
	end

	logic [DATA_W-1:0] val_q;
	logic [2:0]        st_q;
	always_ff @(posedge clk) begin
		if (done) begin
			val_q <= (st != ST_OK || (!busy && command == CMD_CLEAR)) ? '0 : dp_val;
			st_q  <= st;
		end
	end

	assign result_value = $signed(val_q);
	assign status       = st_q;
	assign stack_depth  = dp_depth;
endmodule

>>> test/tb_stack_expression_alu_core.sv
module tb_stack_expression_alu_core;
	import sea_pkg::*;

	// Stack capacity of the instance; the predictor uses the same bound.
	localparam int CAP = STACK_DEPTH_DEF;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [1:0]               command;
	logic signed [DATA_W-1:0] operand_value;
	logic [4:0]               opcode;
	logic                     result_valid;
	logic signed [DATA_W-1:0] result_value;
	logic [2:0]               status;
	logic [DEPTH_W-1:0]       stack_depth;

	stack_expression_alu_core #(.STACK_DEPTH(CAP)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .operand_value(operand_value), .opcode(opcode),
		.result_valid(result_valid), .result_value(result_value),
		.status(status), .stack_depth(stack_depth)
	);

	// One expected answer per command.
	typedef struct packed {
		logic [31:0] value;
		logic [2:0]  st;
		logic [6:0]  depth;
	} answer_t;

	answer_t     answer_q[$];
	logic [31:0] shadow_stack[CAP];
	int          shadow_count;
	int          mismatch_count;
	int          orphan_count;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Integer ALU as seen from outside: y op x, 32-bit wrap.
	function automatic logic [31:0] alu_eval(logic [4:0] op, logic [31:0] y, logic [31:0] x);
		logic signed [31:0] sy;
		logic signed [31:0] sx;
		sy = y;
		sx = x;
		case (op)
			OP_ADD:  return y + x;
			OP_SUB:  return y - x;
			OP_MUL:  return y * x;
			// most negative / -1 wraps, remainder 0
			OP_DIV: begin
				if (sy == 32'sh80000000 && sx == -1) return 32'h80000000;
				return sy / sx;
			end
			OP_MOD: begin
				if (sx == -1) return 32'd0;
				return sy % sx;
			end
			OP_LT:   return {31'd0, sy < sx};
			OP_GT:   return {31'd0, sy > sx};
			OP_LE:   return {31'd0, sy <= sx};
			OP_GE:   return {31'd0, sy >= sx};
			OP_NE:   return {31'd0, y != x};
			OP_LAND: return {31'd0, (y != 0) && (x != 0)};
			OP_LOR:  return {31'd0, (y != 0) || (x != 0)};
			OP_EQ:   return {31'd0, y == x};
			OP_OR:   return y | x;
			OP_AND:  return y & x;
			OP_XOR:  return y ^ x;
			// out-of-range count: zero left, sign fill right
			OP_SHL:  return (x > 32'd31) ? 32'd0 : y << x[4:0];
			default: begin
				if (x > 32'd31) return {32{y[31]}};
				return sy >>> x[4:0];
			end
		endcase
	endfunction

	// Apply one command to the shadow stack and queue its answer.
	function automatic void predict_command(logic [1:0] cmd, logic [31:0] val, logic [4:0] op);
		answer_t     a;
		logic [31:0] x;
		logic [31:0] y;
		a.value = 32'd0;
		a.st = ST_OK;
		case (cmd)
			CMD_CLEAR: shadow_count = 0;
			CMD_PUSH: begin
				if (shadow_count >= CAP) begin
					a.st = ST_OVERFLOW;
				end else begin
					shadow_stack[shadow_count] = val;
					shadow_count++;
					a.value = val;
				end
			end
			CMD_POP: begin
				if (shadow_count == 0) begin
					a.st = ST_UNDERFLOW;
				end else begin
					shadow_count--;
					a.value = shadow_stack[shadow_count];
				end
			end
			default: begin
				if (shadow_count < 2) begin
					a.st = ST_UNDERFLOW;
				end else if (op > OP_SHR) begin
					a.st = ST_BADOP;
				end else begin
					x = shadow_stack[shadow_count-1];
					y = shadow_stack[shadow_count-2];
					shadow_count -= 2;
					if ((op == OP_DIV || op == OP_MOD) && x == 32'd0) begin
						a.st = ST_DIVZERO;
					end else begin
						a.value = alu_eval(op, y, x);
						shadow_stack[shadow_count] = a.value;
						shadow_count++;
					end
				end
			end
		endcase
		a.depth = shadow_count[6:0];
		answer_q.push_back(a);
	endfunction

	// Burst/gap pacing for the sender.
	int burst_left;

	// Send one command beat: hold start until accepted (start & !busy at edge).
	task automatic send_beat(logic [1:0] cmd, logic [31:0] val, logic [4:0] op);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				start <= 1'b0;
				// scramble the idle payload; the block must ignore it
				operand_value <= $urandom;
				opcode <= 5'($urandom);
				command <= 2'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		command <= cmd;
		operand_value <= val;
		opcode <= op;
		do @(posedge clk); while (busy);
		// accepted at this edge
		predict_command(cmd, val, op);
	endtask

	// Result checker: every strobe is a beat, compared with the oldest answer.
	always @(posedge clk) begin
		answer_t a;
		if (arst_n && result_valid) begin
			if (answer_q.size() == 0) begin
				orphan_count++;
				if (mismatch_count + orphan_count <= 10)
					$display("unexpected result beat: value %h status %0d depth %0d",
						result_value, status, stack_depth);
			end else begin
				a = answer_q.pop_front();
				if (result_value !== a.value || status !== a.st || stack_depth !== a.depth) begin
					mismatch_count++;
					if (mismatch_count + orphan_count <= 10)
						$display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
							a.value, a.st, a.depth, result_value, status, stack_depth);
				end
			end
		end
	end

	function automatic logic [31:0] edge_value();
		case ($urandom_range(0, 7))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'hffffffff;
			3: return 32'd0;
			4: return 32'd1;
			5: return $urandom_range(0, 40);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		logic [4:0] op;
		send_beat(CMD_POP, 32'd0, OP_ADD);           // pop on empty
		send_beat(CMD_BINOP, 32'd0, OP_ADD);         // binop on empty
		send_beat(CMD_PUSH, 32'h80000000, OP_ADD);
		send_beat(CMD_BINOP, 32'd0, OP_SUB);         // binop with one entry
		send_beat(CMD_PUSH, 32'hffffffff, OP_ADD);
		send_beat(CMD_BINOP, 32'd0, OP_DIV);         // most negative / -1
		send_beat(CMD_PUSH, 32'hffffffff, OP_ADD);
		send_beat(CMD_BINOP, 32'd0, OP_MOD);
		send_beat(CMD_PUSH, 32'h7fffffff, OP_ADD);
		send_beat(CMD_PUSH, 32'd0, OP_ADD);
		send_beat(CMD_BINOP, 32'd0, OP_DIV);         // divide by zero
		send_beat(CMD_PUSH, 32'd5, OP_ADD);
		send_beat(CMD_PUSH, 32'd3, OP_ADD);
		send_beat(CMD_BINOP, 32'd0, 5'd31);          // bad opcode, nothing popped
		send_beat(CMD_BINOP, 32'd0, 5'd18);
		send_beat(CMD_PUSH, 32'hffffff9c, OP_ADD);
		send_beat(CMD_BINOP, 32'd0, OP_SHR);         // negative shift count
		send_beat(CMD_PUSH, 32'd32, OP_ADD);
		send_beat(CMD_BINOP, 32'd0, OP_SHL);         // shift count 32
		send_beat(CMD_POP, 32'd0, OP_ADD);
		send_beat(CMD_CLEAR, 32'hffffffff, 5'd31);
		// every operation once on mostly extreme operands
		for (op = OP_ADD; op <= OP_SHR; op++) begin
			send_beat(CMD_PUSH, edge_value(), OP_ADD);
			send_beat(CMD_PUSH, edge_value(), OP_ADD);
			send_beat(CMD_BINOP, 32'd0, op);
		end
		send_beat(CMD_CLEAR, 32'd0, OP_ADD);
	endtask

	// Fill to capacity, overflow, then drain past empty.
	task automatic test_full_stack();
		for (int i = 0; i < CAP + 2; i++) send_beat(CMD_PUSH, $urandom, OP_ADD);
		send_beat(CMD_BINOP, 32'd0, OP_XOR);
		send_beat(CMD_PUSH, 32'd7, OP_ADD);
		for (int i = 0; i < CAP + 2; i++) send_beat(CMD_POP, $urandom, 5'($urandom));
	endtask

	// Random command mix: mostly pushes and binary operations, some pops, rare clears.
	task automatic test_random_expressions(int n);
		int          r;
		logic [31:0] v;
		logic [4:0]  op;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			v = edge_value();
			// mostly valid opcodes, sometimes any 5-bit value
			op = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 17));
			if (r < 45) send_beat(CMD_PUSH, v, 5'($urandom));
			else if (r < 85) send_beat(CMD_BINOP, $urandom, op);
			else if (r < 97) send_beat(CMD_POP, $urandom, 5'($urandom));
			else send_beat(CMD_CLEAR, $urandom, 5'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_CLEAR;
		operand_value = '0;
		opcode = OP_ADD;
		shadow_count = 0;
		mismatch_count = 0;
		orphan_count = 0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_stack();
		test_random_expressions(1700);
		start <= 1'b0;
		while (answer_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatch_count == 0 && orphan_count == 0 && answer_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog: generous bound for about 2000 beats with random gaps and divides.
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
